// ===== hw/rtl/integer_alu_with_divide_top_macros.svh =====
// Assertion macros used by the top-level RTL.
`ifndef INTEGER_ALU_WITH_DIVIDE_TOP_MACROS_SVH
`define INTEGER_ALU_WITH_DIVIDE_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define IAD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define IAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/iad_pkg.sv =====
package iad_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int OP_WIDTH   = 3;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_REM = 3'd4,
        OP_AND = 3'd5,
        OP_OR  = 3'd6,
        OP_NOT = 3'd7
    } t_op;

    typedef struct packed {
        logic                  valid;
        t_op                   op;
        logic                  neg_q;
        logic                  neg_r;
        logic                  div_zero;
        logic [DATA_WIDTH-1:0] divisor;
        logic [DATA_WIDTH-1:0] part_rem;
        logic [DATA_WIDTH-1:0] quo;
        logic [DATA_WIDTH-1:0] res;
    } t_cell;

endpackage

// ===== hw/rtl/iad_req_if.sv =====
interface iad_req_if
    import iad_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic [OP_WIDTH-1:0]          operation;
    logic signed [DATA_WIDTH-1:0] operand_a;
    logic signed [DATA_WIDTH-1:0] operand_b;

    modport source (output valid, output operation, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input operation, input operand_a, input operand_b,
                    output ready);
endinterface

// ===== hw/rtl/iad_res_if.sv =====
interface iad_res_if
    import iad_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] result_value;
    logic                         status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

// ===== hw/rtl/iad_front.sv =====
module iad_front
    import iad_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  logic [OP_WIDTH-1:0]   i_op,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    output t_cell                 o_cell
);

    t_cell                 r_cell;
    t_cell                 n_cell;
    t_op                   w_op;
    logic [DATA_WIDTH-1:0] w_mag_a;
    logic [DATA_WIDTH-1:0] w_mag_b;
    logic [DATA_WIDTH-1:0] w_mul;

    assign w_op    = t_op'(i_op);
    assign w_mag_a = i_a[DATA_WIDTH-1] ? (~i_a + 1'b1) : i_a;
    assign w_mag_b = i_b[DATA_WIDTH-1] ? (~i_b + 1'b1) : i_b;
    assign w_mul   = i_a * i_b;

    always_comb begin
        n_cell          = '0;
        n_cell.valid    = i_valid;
        n_cell.op       = w_op;
        n_cell.neg_q    = i_a[DATA_WIDTH-1] ^ i_b[DATA_WIDTH-1];
        n_cell.neg_r    = i_a[DATA_WIDTH-1];
        n_cell.div_zero = (i_b == '0);
        n_cell.divisor  = w_mag_b;
        n_cell.part_rem = '0;
        n_cell.quo      = w_mag_a;
        unique case (w_op)
            OP_ADD: n_cell.res = i_a + i_b;
            OP_SUB: n_cell.res = i_a - i_b;
            OP_MUL: n_cell.res = w_mul;
            OP_DIV: n_cell.res = '0;
            OP_REM: n_cell.res = '0;
            OP_AND: n_cell.res = i_a & i_b;
            OP_OR:  n_cell.res = i_a | i_b;
            OP_NOT: n_cell.res = ~i_a;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_adv) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_adv) begin
            r_cell.op       <= n_cell.op;
            r_cell.neg_q    <= n_cell.neg_q;
            r_cell.neg_r    <= n_cell.neg_r;
            r_cell.div_zero <= n_cell.div_zero;
            r_cell.divisor  <= n_cell.divisor;
            r_cell.part_rem <= n_cell.part_rem;
            r_cell.quo      <= n_cell.quo;
            r_cell.res      <= n_cell.res;
        end
    end

    assign o_cell = r_cell;

endmodule

// ===== hw/rtl/iad_cell.sv =====
module iad_cell
    import iad_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  t_cell i_prev,
    output t_cell o_cur
);

    t_cell               r_cell;
    t_cell               n_cell;
    logic [DATA_WIDTH:0] w_shift;
    logic [DATA_WIDTH:0] w_trial;
    logic                w_bit;

    assign w_shift = {i_prev.part_rem, i_prev.quo[DATA_WIDTH-1]};
    assign w_trial = w_shift - {1'b0, i_prev.divisor};
    assign w_bit   = ~w_trial[DATA_WIDTH];

    always_comb begin
        n_cell          = i_prev;
        n_cell.part_rem = w_bit ? w_trial[DATA_WIDTH-1:0] : w_shift[DATA_WIDTH-1:0];
        n_cell.quo      = {i_prev.quo[DATA_WIDTH-2:0], w_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_adv) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_adv) begin
            r_cell.op       <= n_cell.op;
            r_cell.neg_q    <= n_cell.neg_q;
            r_cell.neg_r    <= n_cell.neg_r;
            r_cell.div_zero <= n_cell.div_zero;
            r_cell.divisor  <= n_cell.divisor;
            r_cell.part_rem <= n_cell.part_rem;
            r_cell.quo      <= n_cell.quo;
            r_cell.res      <= n_cell.res;
        end
    end

    assign o_cur = r_cell;

endmodule

// ===== hw/rtl/iad_back.sv =====
module iad_back
    import iad_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell                 i_cell,
    input  logic                  i_ready,
    output logic                  o_adv,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_value,
    output logic                  o_status
);

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_value;
    logic                  r_status;
    logic [DATA_WIDTH-1:0] n_value;
    logic                  n_status;
    logic                  w_is_div;

    assign o_adv    = ~r_valid | i_ready;
    assign w_is_div = (i_cell.op == OP_DIV) || (i_cell.op == OP_REM);

    always_comb begin
        n_status = w_is_div & i_cell.div_zero;
        if (n_status) begin
            n_value = '0;
        end else if (i_cell.op == OP_DIV) begin
            n_value = i_cell.neg_q ? (~i_cell.quo + 1'b1) : i_cell.quo;
        end else if (i_cell.op == OP_REM) begin
            n_value = i_cell.neg_r ? (~i_cell.part_rem + 1'b1) : i_cell.part_rem;
        end else begin
            n_value = i_cell.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_value  <= n_value;
            r_status <= n_status;
        end
    end

    assign o_valid  = r_valid;
    assign o_value  = r_value;
    assign o_status = r_status;

endmodule

// ===== hw/rtl/integer_alu_with_divide_top.sv =====
// Channel   Dir   Payload                                Handshake
// i_req     in    operation, operand_a, operand_b         valid / ready
// o_res     out   result_value, status                    valid / ready
//
// One item per cycle while the output is not held; each item passes the input stage,
// one restoring divide cell per quotient bit, and the output register.
// All items take the same path, so results leave in order.
// A held output register freezes the whole chain and drops i_req.ready.
// Reset is synchronous and clears only the valid bits.
`include "integer_alu_with_divide_top_macros.svh"

module integer_alu_with_divide_top
    import iad_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    iad_req_if.sink   i_req,
    iad_res_if.source o_res
);

    t_cell w_chain [0:DATA_WIDTH];
    logic  w_adv;

    assign i_req.ready = w_adv;

    iad_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_req.valid),
        .i_op    (i_req.operation),
        .i_a     (i_req.operand_a),
        .i_b     (i_req.operand_b),
        .o_cell  (w_chain[0])
    );

    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_cell
        iad_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_prev  (w_chain[g]),
            .o_cur   (w_chain[g+1])
        );
    end

    iad_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cell   (w_chain[DATA_WIDTH]),
        .i_ready  (o_res.ready),
        .o_adv    (w_adv),
        .o_valid  (o_res.valid),
        .o_value  (o_res.result_value),
        .o_status (o_res.status)
    );

    `IAD_ASSERT_NOW(a_stall_blocks_input, i_clk, i_rst_n, o_res.valid && !o_res.ready, !i_req.ready, "input taken while output stalled")
    `IAD_ASSERT_NOW(a_empty_takes_input, i_clk, i_rst_n, !o_res.valid, i_req.ready, "input refused with empty output")
    `IAD_ASSERT_NOW(a_zero_div_value, i_clk, i_rst_n, o_res.valid && o_res.status, o_res.result_value == '0, "nonzero result with divide-by-zero status")
    `IAD_ASSERT_NEXT(a_chain_holds, i_clk, i_rst_n, !w_adv, $stable(w_chain[DATA_WIDTH].valid) && $stable(o_res.valid), "chain moved during stall")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import iad_pkg::*;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_DIV_ZERO = 1'b1;

    localparam logic [DATA_WIDTH-1:0] WORD_MIN  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] WORD_MAX  = ~WORD_MIN;
    localparam logic [DATA_WIDTH-1:0] WORD_ZERO = '0;
    localparam logic [DATA_WIDTH-1:0] WORD_ONE  = 1;
    localparam logic [DATA_WIDTH-1:0] WORD_NEG1 = '1;

    localparam int RANDOM_ITEMS = 450;
    localparam int TAIL_ITEMS   = 80;
    localparam int DRAIN_CYCLES = DATA_WIDTH + 10;

    typedef struct {
        t_op                   op;
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
    } t_alu_req;

    typedef struct {
        logic [DATA_WIDTH-1:0] value;
        logic                  status;
    } t_alu_res;

    logic clk;
    logic rst_n;

    iad_req_if req_ch ();
    iad_res_if res_ch ();

    integer_alu_with_divide_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    t_alu_req    pending_reqs[$];
    t_alu_res    expected_results[$];
    t_alu_req    sent_req;
    t_alu_res    want;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned results_seen;
    int unsigned num_items;
    int unsigned mismatch_count;

    function automatic t_alu_res alu_predict(t_alu_req r);
        t_alu_res              res;
        logic [DATA_WIDTH-1:0] mag_a;
        logic [DATA_WIDTH-1:0] mag_b;
        logic [DATA_WIDTH-1:0] mag;
        res.value  = '0;
        res.status = STATUS_OK;
        mag_a = r.a[DATA_WIDTH-1] ? -r.a : r.a;
        mag_b = r.b[DATA_WIDTH-1] ? -r.b : r.b;
        case (r.op)
            OP_ADD: res.value = r.a + r.b;
            OP_SUB: res.value = r.a - r.b;
            OP_MUL: res.value = r.a * r.b;
            OP_DIV, OP_REM: begin
                if (r.b == WORD_ZERO) begin
                    res.status = STATUS_DIV_ZERO;
                end else if (r.op == OP_DIV) begin
                    mag = mag_a / mag_b;
                    res.value = (r.a[DATA_WIDTH-1] ^ r.b[DATA_WIDTH-1]) ? -mag : mag;
                end else begin
                    mag = mag_a % mag_b;
                    res.value = r.a[DATA_WIDTH-1] ? -mag : mag;
                end
            end
            OP_AND: res.value = r.a & r.b;
            OP_OR:  res.value = r.a | r.b;
            default: res.value = ~r.a;
        endcase
        return res;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_operand();
        logic [DATA_WIDTH-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 16)) - 8;
            2: begin
                case ($urandom_range(0, 4))
                    0: v = WORD_MIN;
                    1: v = WORD_MAX;
                    2: v = WORD_ZERO;
                    3: v = WORD_ONE;
                    default: v = WORD_NEG1;
                endcase
            end
            default: begin
                v = $urandom >> $urandom_range(0, DATA_WIDTH - 1);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic bit idle_window(int unsigned n);
        return (n / 40) % 3 != 0;
    endfunction

    task automatic add_item(t_op op, logic [DATA_WIDTH-1:0] a, logic [DATA_WIDTH-1:0] b);
        t_alu_req r;
        r.op = op;
        r.a  = a;
        r.b  = b;
        pending_reqs.push_back(r);
    endtask

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
            send_gap = 0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (req_ch.valid)
                expected_results.push_back(alu_predict(sent_req));
            if (send_gap != 0) begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() > TAIL_ITEMS && idle_window(pending_reqs.size())
                         && $urandom_range(0, 3) == 0) begin
                send_gap = $urandom_range(0, 2);
                req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                sent_req = pending_reqs.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.operation <= sent_req.op;
                req_ch.operand_a <= sent_req.a;
                req_ch.operand_b <= sent_req.b;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: result_value %h status %b",
                           res_ch.result_value, res_ch.status);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (res_ch.result_value !== want.value) begin
                        $error("result_value: expected %h, actual %h",
                               want.value, res_ch.result_value);
                        mismatch_count++;
                    end
                    if (res_ch.status !== want.status) begin
                        $error("status: expected %b, actual %b", want.status, res_ch.status);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (results_seen + TAIL_ITEMS < num_items && idle_window(results_seen)
                         && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 2);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        #100000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [DATA_WIDTH-1:0] ra;
        logic [DATA_WIDTH-1:0] rb;
        t_op                   rop;
        clk              = 1'b0;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_ADD;
        req_ch.operand_a = '0;
        req_ch.operand_b = '0;
        res_ch.ready     = 1'b0;
        results_seen     = 0;
        mismatch_count   = 0;

        add_item(OP_ADD, WORD_MAX, WORD_ONE);
        add_item(OP_ADD, WORD_MIN, WORD_NEG1);
        add_item(OP_SUB, WORD_MIN, WORD_ONE);
        add_item(OP_SUB, WORD_ZERO, WORD_MIN);
        add_item(OP_MUL, WORD_MAX, WORD_MAX);
        add_item(OP_MUL, WORD_MIN, WORD_NEG1);
        add_item(OP_MUL, WORD_NEG1, WORD_NEG1);
        add_item(OP_DIV, WORD_MIN, WORD_NEG1);
        add_item(OP_REM, WORD_MIN, WORD_NEG1);
        add_item(OP_DIV, WORD_MAX, WORD_ZERO);
        add_item(OP_REM, WORD_MIN, WORD_ZERO);
        add_item(OP_DIV, -32'sd7, 32'sd2);
        add_item(OP_REM, -32'sd7, 32'sd2);
        add_item(OP_DIV, 32'sd7, -32'sd2);
        add_item(OP_REM, 32'sd7, -32'sd2);
        add_item(OP_DIV, WORD_MAX, WORD_MIN);
        add_item(OP_REM, WORD_MIN, WORD_MIN);
        add_item(OP_DIV, WORD_ZERO, WORD_NEG1);
        add_item(OP_AND, WORD_NEG1, WORD_MIN);
        add_item(OP_AND, WORD_ZERO, WORD_NEG1);
        add_item(OP_OR, WORD_ZERO, WORD_ZERO);
        add_item(OP_OR, WORD_MIN, WORD_MAX);
        add_item(OP_NOT, WORD_ZERO, WORD_NEG1);
        add_item(OP_NOT, WORD_MIN, WORD_ZERO);
        add_item(OP_NOT, 32'h5a5a_a5a5, 32'h1234_5678);

        repeat (RANDOM_ITEMS) begin
            rop = t_op'($urandom_range(0, 7));
            ra  = pick_operand();
            rb  = pick_operand();
            if ((rop == OP_DIV || rop == OP_REM) && $urandom_range(0, 7) == 0)
                rb = WORD_ZERO;
            add_item(rop, ra, rb);
        end
        num_items = pending_reqs.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
